@@ src/ost_pkg.sv @@
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants for the ordered set table.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 5;

  // operation codes; codes 5..7 are ignored by the block
  typedef enum logic [MODE_W-1:0] {
    OP_ADD      = 3'd0,
    OP_CONTAINS = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_GET      = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_GET,
    ST_DONE
  } state_t;

endpackage

@@ src/ost_in_if.sv @@
// ----------------------------------------------------------------------------
// ost_in_if
// Request channel: one operation per transaction.
// ----------------------------------------------------------------------------
interface ost_in_if;
  logic                                valid;
  logic                                ready;
  logic [ost_pkg::MODE_W-1:0]          mode;
  logic signed [ost_pkg::VALUE_W-1:0]  elem_value;
  logic [ost_pkg::POS_W-1:0]           position;

  modport source (output valid, mode, elem_value, position, input ready);
  modport sink   (input valid, mode, elem_value, position, output ready);
endinterface

@@ src/ost_out_if.sv @@
// ----------------------------------------------------------------------------
// ost_out_if
// Result channel: one result per request transaction.
// ----------------------------------------------------------------------------
interface ost_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [ost_pkg::VALUE_W-1:0]  read_value;
  logic [ost_pkg::COUNT_W-1:0]         entry_count;
  logic                                full_res;

  modport source (output valid, found, read_value, entry_count, full_res, input ready);
  modport sink   (input valid, found, read_value, entry_count, full_res, output ready);
endinterface

@@ src/ordered_set_table_top.sv @@
// ----------------------------------------------------------------------------
// ordered_set_table_top
// Bounded set of distinct signed 32-bit values kept in insertion order.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_chan.ready is high only while the
// sequencer is idle. The values live in a single-port-read, single-port-write
// synchronous RAM of CAPACITY words, and all searching goes through its one
// read port, one entry per cycle, pipelined against the compare. Clear and
// unused codes go straight to the result, get reads the addressed entry if
// it is below the count, and add and contains scan until a hit or the last
// entry. Remove of the last entry ends like a hit; remove of an earlier entry
// first finds it, then closes up the later entries one slot down, then loads
// the result. The sequencer returns to idle with the load, so the next
// transaction can be taken in the following cycle. The result sits in an
// output register, so a result can wait for out_chan.ready while the next
// request is already being worked on; a finished result holds the sequencer
// only if the previous one has not yet been taken. Entries at or above the
// count are never read, so the RAM needs no clearing after reset; count
// resets to zero.
// ----------------------------------------------------------------------------
module ordered_set_table_top #(
  parameter int CAPACITY = ost_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ost_in_if.sink         in_chan,
  ost_out_if.source      out_chan
);

  localparam int CW   = $clog2(CAPACITY + 1);   // count width
  localparam int IW   = $clog2(CAPACITY);       // RAM address width
  localparam int CMPW = (CW > ost_pkg::POS_W) ? CW : ost_pkg::POS_W;
  localparam int VW   = ost_pkg::VALUE_W;

  // sequencer state
  ost_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;     // next RAM address to issue
  logic [CW-1:0]   cmp_idx_r, cmp_idx_nxt;   // index of mem_q (scan) or write target (shift)
  logic            rvld_r, rvld_nxt;         // mem_q holds data issued last cycle

  // latched request
  logic [ost_pkg::MODE_W-1:0] mode_r;
  logic [VW-1:0]              val_r;

  // pending result
  logic          res_found_r, res_found_nxt;
  logic [VW-1:0] res_rd_r, res_rd_nxt;
  logic          res_full_r, res_full_nxt;

  // output register
  logic                       out_valid_r;
  logic                       out_found_r;
  logic [VW-1:0]              out_rd_r;
  logic [ost_pkg::COUNT_W-1:0] out_count_r;
  logic                       out_full_r;
  logic                       out_load;

  // entry RAM
  logic [VW-1:0] entries [CAPACITY];
  logic [VW-1:0] mem_q;
  logic          mem_rd_en;
  logic [IW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  logic [VW-1:0] mem_wr_data;

  logic          in_acc;
  logic          hit;
  logic          miss;
  logic [CW-1:0] last_idx;

  assign in_chan.ready = (state_r == ost_pkg::ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign last_idx = count_r - CW'(1);
  assign hit      = rvld_r && (mem_q == val_r);
  assign miss     = (count_r == '0) || (rvld_r && !hit && (cmp_idx_r == last_idx));

  always_ff @(posedge clk) begin
    if (mem_wr_en) entries[mem_wr_addr] <= mem_wr_data;
    if (mem_rd_en) mem_q <= entries[mem_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ost_pkg::ST_IDLE;
      count_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_found_r <= res_found_nxt;
    res_rd_r    <= res_rd_nxt;
    res_full_r  <= res_full_nxt;
    if (in_acc) begin
      mode_r <= in_chan.mode;
      val_r  <= in_chan.elem_value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    rvld_nxt      = 1'b0;
    res_found_nxt = res_found_r;
    res_rd_nxt    = res_rd_r;
    res_full_nxt  = res_full_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = rd_idx_r[IW-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = cmp_idx_r[IW-1:0];
    mem_wr_data   = mem_q;
    out_load      = 1'b0;

    case (state_r)
      ost_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_found_nxt = 1'b0;
          res_rd_nxt    = '1;
          res_full_nxt  = 1'b0;
          rd_idx_nxt    = '0;
          case (in_chan.mode)
            ost_pkg::OP_ADD, ost_pkg::OP_CONTAINS, ost_pkg::OP_REMOVE: begin
              state_nxt = ost_pkg::ST_SCAN;
            end
            ost_pkg::OP_GET: begin
              if (CMPW'(in_chan.position) < CMPW'(count_r)) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = in_chan.position[IW-1:0];
                state_nxt   = ost_pkg::ST_GET;
              end else begin
                state_nxt = ost_pkg::ST_DONE;
              end
            end
            ost_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              res_found_nxt = 1'b1;
              state_nxt     = ost_pkg::ST_DONE;
            end
            default: state_nxt = ost_pkg::ST_DONE;
          endcase
        end
      end

      ost_pkg::ST_SCAN: begin
        // keep one read in flight ahead of the compare
        if (rd_idx_r < count_r) begin
          mem_rd_en   = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_idx_nxt = rd_idx_r;
          rvld_nxt    = 1'b1;
        end
        if (hit) begin
          rvld_nxt = 1'b0;
          case (mode_r)
            ost_pkg::OP_CONTAINS: begin
              res_found_nxt = 1'b1;
              state_nxt     = ost_pkg::ST_DONE;
            end
            ost_pkg::OP_REMOVE: begin
              if (cmp_idx_r == last_idx) begin
                count_nxt     = last_idx;
                res_found_nxt = 1'b1;
                state_nxt     = ost_pkg::ST_DONE;
              end else begin
                // close up: read p+1 onward, write each one slot down
                rd_idx_nxt = cmp_idx_r + CW'(1);
                state_nxt  = ost_pkg::ST_SHIFT;
              end
            end
            default: state_nxt = ost_pkg::ST_DONE;   // add of a held value
          endcase
        end else if (miss) begin
          rvld_nxt = 1'b0;
          if (mode_r == ost_pkg::OP_ADD) begin
            if (count_r < CW'(CAPACITY)) begin
              mem_wr_en     = 1'b1;
              mem_wr_addr   = count_r[IW-1:0];
              mem_wr_data   = val_r;
              count_nxt     = count_r + CW'(1);
              res_found_nxt = 1'b1;
            end else begin
              res_full_nxt = 1'b1;
            end
          end
          state_nxt = ost_pkg::ST_DONE;
        end
      end

      ost_pkg::ST_SHIFT: begin
        if (rd_idx_r < count_r) begin
          mem_rd_en   = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_idx_nxt = rd_idx_r - CW'(1);
          rvld_nxt    = 1'b1;
        end
        if (rvld_r) begin
          mem_wr_en = 1'b1;
          if (cmp_idx_r == count_r - CW'(2)) begin
            rvld_nxt      = 1'b0;
            count_nxt     = last_idx;
            res_found_nxt = 1'b1;
            state_nxt     = ost_pkg::ST_DONE;
          end
        end
      end

      ost_pkg::ST_GET: begin
        res_rd_nxt    = mem_q;
        res_found_nxt = 1'b1;
        state_nxt     = ost_pkg::ST_DONE;
      end

      ost_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ost_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ost_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= res_found_r;
      out_rd_r    <= res_rd_r;
      out_count_r <= ost_pkg::COUNT_W'(count_r);
      out_full_r  <= res_full_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.read_value  = out_rd_r;
  assign out_chan.entry_count = out_count_r;
  assign out_chan.full_res    = out_full_r;

endmodule

@@ src/ordered_set_table_chk.sv @@
// ----------------------------------------------------------------------------
// ordered_set_table_chk
// Port-level checks for the ordered set table, bound to the top level.
// ----------------------------------------------------------------------------
module ordered_set_table_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_found,
  input logic signed [ost_pkg::VALUE_W-1:0] out_read_value,
  input logic [ost_pkg::COUNT_W-1:0]        out_entry_count,
  input logic                               out_full_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_read_value) && $stable(out_entry_count) && $stable(out_full_res))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  // reset leaves no stale result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_set_table_top ordered_set_table_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_found       (out_chan.found),
  .out_read_value  (out_chan.read_value),
  .out_entry_count (out_chan.entry_count),
  .out_full_res    (out_chan.full_res)
);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ordered_set_table_top. A short directed script
// covers the empty, full and boundary cases, then random operations with values
// mostly from a small pool exercise every operation code against a shadow table.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAP = ost_pkg::CAPACITY_DEF;
  localparam int RANDOM_OPS = 1650;
  localparam int POOL_N = 24;
  localparam int HELD_AW = $clog2(CAP);
  localparam int POOL_AW = $clog2(POOL_N);

  // codes the block ignores
  localparam logic [ost_pkg::MODE_W-1:0] MODE_RSV5 = 3'd5;
  localparam logic [ost_pkg::MODE_W-1:0] MODE_RSV6 = 3'd6;
  localparam logic [ost_pkg::MODE_W-1:0] MODE_RSV7 = 3'd7;

  localparam logic signed [ost_pkg::VALUE_W-1:0] NO_VALUE = -32'sd1;
  localparam logic signed [ost_pkg::VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [ost_pkg::VALUE_W-1:0] VAL_MAX  = 32'sh7fff_ffff;

  typedef struct packed {
    logic                               found;
    logic signed [ost_pkg::VALUE_W-1:0] read_value;
    logic [ost_pkg::COUNT_W-1:0]        entry_count;
    logic                               full_res;
  } result_t;

  // one line of the directed script; reps > 1 steps value and position by one
  typedef struct packed {
    logic [ost_pkg::MODE_W-1:0]         mode;
    logic signed [ost_pkg::VALUE_W-1:0] value;
    logic [ost_pkg::POS_W-1:0]          pos;
    logic [4:0]                         reps;
    logic                               typed;
    result_t                            want;
  } script_row_t;

  logic clk;
  logic rst_n;

  ost_in_if  in_if ();
  ost_out_if out_if ();

  ordered_set_table_top #(.CAPACITY(CAP)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // shadow copy of the table, updated at accept time
  logic signed [ost_pkg::VALUE_W-1:0] held [CAP];
  int                                 held_count;

  result_t     pending_results[$];
  script_row_t script[$];
  logic signed [ost_pkg::VALUE_W-1:0] pool [POOL_N];

  bit no_idle;
  int mismatches;
  int results_checked;
  int ops_sent;
  int directed_sent;
  int refused_full;
  int op_hits [8];

  // Apply one operation to the shadow table and return what the block should say.
  function automatic result_t apply_op(input logic [ost_pkg::MODE_W-1:0] mode,
                                       input logic signed [ost_pkg::VALUE_W-1:0] v,
                                       input logic [ost_pkg::POS_W-1:0] pos);
    result_t r;
    int      hit;
    int      i;
    r.found      = 1'b0;
    r.read_value = NO_VALUE;
    r.full_res   = 1'b0;
    // first position holding v, or held_count if absent
    hit = held_count;
    for (i = held_count - 1; i >= 0; i--)
      if (held[HELD_AW'(i)] == v) hit = i;
    case (mode)
      ost_pkg::OP_ADD: begin
        if (hit == held_count) begin
          if (held_count < CAP) begin
            held[HELD_AW'(held_count)] = v;
            held_count++;
            r.found = 1'b1;
          end else begin
            r.full_res = 1'b1;
          end
        end
      end
      ost_pkg::OP_CONTAINS: r.found = (hit < held_count);
      ost_pkg::OP_REMOVE: begin
        if (hit < held_count) begin
          for (i = hit; i < held_count - 1; i++)
            held[HELD_AW'(i)] = held[HELD_AW'(i + 1)];
          held_count--;
          r.found = 1'b1;
        end
      end
      ost_pkg::OP_GET: begin
        if (int'(pos) < held_count) begin
          r.read_value = held[pos[HELD_AW-1:0]];
          r.found      = 1'b1;
        end
      end
      ost_pkg::OP_CLEAR: begin
        held_count = 0;
        r.found    = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = ost_pkg::COUNT_W'(held_count);
    return r;
  endfunction

  // mostly back-to-back, now and then a long hold-off
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [ost_pkg::MODE_W-1:0] mode,
                         input logic signed [ost_pkg::VALUE_W-1:0] v,
                         input logic [ost_pkg::POS_W-1:0] pos, input int reps,
                         input bit typed, input logic f,
                         input logic signed [ost_pkg::VALUE_W-1:0] rd,
                         input int cnt, input logic full);
    script_row_t row;
    row.mode  = mode;
    row.value = v;
    row.pos   = pos;
    row.reps  = 5'(reps);
    row.typed = typed;
    row.want  = '{f, rd, ost_pkg::COUNT_W'(cnt), full};
    script.push_back(row);
  endtask

  // Drive one transaction, wait for acceptance, then log what should come back.
  task automatic send_op(input logic [ost_pkg::MODE_W-1:0] mode,
                         input logic signed [ost_pkg::VALUE_W-1:0] v,
                         input logic [ost_pkg::POS_W-1:0] pos, input bit typed,
                         input result_t want);
    int      gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.elem_value <= v;
    in_if.position   <= pos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    r = apply_op(mode, v, pos);
    pending_results.push_back(typed ? want : r);
    ops_sent++;
    op_hits[mode]++;
    if (r.full_res) refused_full++;
  endtask

  // Result side: random back-pressure on out ready.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.found, out_if.read_value, out_if.entry_count, out_if.full_res};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result found=%0b value=%0d count=%0d full=%0b",
                   got.found, got.read_value, got.entry_count, got.full_res);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.found !== want.found || got.read_value !== want.read_value ||
            got.entry_count !== want.entry_count || got.full_res !== want.full_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d exp found=%0b value=%0d count=%0d full=%0b",
                     results_checked, want.found, want.read_value, want.entry_count,
                     want.full_res);
            $display("       got found=%0b value=%0d count=%0d full=%0b",
                     got.found, got.read_value, got.entry_count, got.full_res);
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("ordered_set_table_top verification failed");
    $finish;
  end

  initial begin
    script_row_t                        row;
    logic [ost_pkg::MODE_W-1:0]         mode;
    logic signed [ost_pkg::VALUE_W-1:0] v;
    logic [ost_pkg::POS_W-1:0]          pos;
    int                                 roll;
    int                                 k;
    int                                 j;

    in_if.valid      <= 1'b0;
    in_if.mode       <= ost_pkg::OP_ADD;
    in_if.elem_value <= '0;
    in_if.position   <= '0;
    rst_n            <= 1'b0;
    held_count = 0;
    no_idle    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script. Typed rows carry the obvious answer; the rest use
    // the shadow table.
    add_row(ost_pkg::OP_GET,      0,        0,   1, 1, 0, NO_VALUE, 0,  0); // empty get
    add_row(ost_pkg::OP_REMOVE,   5,        0,   1, 1, 0, NO_VALUE, 0,  0); // remove absent
    add_row(MODE_RSV5,            NO_VALUE, 255, 1, 1, 0, NO_VALUE, 0,  0); // unused code
    add_row(ost_pkg::OP_ADD,      VAL_MIN,  0,   1, 1, 1, NO_VALUE, 1,  0);
    add_row(ost_pkg::OP_ADD,      VAL_MAX,  0,   1, 1, 1, NO_VALUE, 2,  0);
    add_row(ost_pkg::OP_ADD,      VAL_MIN,  0,   1, 1, 0, NO_VALUE, 2,  0); // duplicate add
    add_row(ost_pkg::OP_GET,      0,        0,   1, 1, 1, VAL_MIN,  2,  0);
    add_row(ost_pkg::OP_GET,      0,        255, 1, 1, 0, NO_VALUE, 2,  0); // past count
    add_row(ost_pkg::OP_CONTAINS, VAL_MAX,  0,   1, 1, 1, NO_VALUE, 2,  0);
    add_row(ost_pkg::OP_ADD,      100,      0,   14, 0, 0, 0, 0, 0);      // fill to capacity
    add_row(ost_pkg::OP_ADD,      NO_VALUE, 0,   1, 1, 0, NO_VALUE, CAP, 1); // refused, full
    add_row(ost_pkg::OP_ADD,      VAL_MAX,  0,   1, 1, 0, NO_VALUE, CAP, 0); // dup while full
    add_row(ost_pkg::OP_GET,      0, ost_pkg::POS_W'(CAP), 1, 1, 0, NO_VALUE, CAP, 0);
    add_row(ost_pkg::OP_REMOVE,   VAL_MIN,  0,   1, 1, 1, NO_VALUE, CAP - 1, 0); // head
    add_row(ost_pkg::OP_REMOVE,   113,      0,   1, 0, 0, 0, 0, 0);       // tail
    add_row(ost_pkg::OP_REMOVE,   105,      0,   1, 0, 0, 0, 0, 0);       // middle
    add_row(ost_pkg::OP_GET,      0,        5,   1, 0, 0, 0, 0, 0);
    add_row(ost_pkg::OP_CLEAR,    0,        0,   1, 1, 1, NO_VALUE, 0,  0);
    add_row(ost_pkg::OP_CONTAINS, VAL_MAX,  0,   1, 1, 0, NO_VALUE, 0,  0);

    foreach (script[i]) begin
      row = script[i];
      for (j = 0; j < row.reps; j++)
        send_op(row.mode, row.value + j, row.pos + ost_pkg::POS_W'(j), row.typed, row.want);
    end
    directed_sent = ops_sent;

    // Random part. A small pool makes hits and duplicates common; phases
    // alternate between filling and draining so the full table is reached
    // often and removals see every position.
    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % 300 == 0) begin
        for (j = 0; j < POOL_N; j++) pool[POOL_AW'(j)] = $urandom;
        pool[0] = VAL_MIN;
        pool[1] = VAL_MAX;
        pool[2] = 0;
        pool[3] = NO_VALUE;
      end
      no_idle = ((k / 100) % 4 == 3);

      roll = $urandom_range(0, 99);
      if ((k / 120) % 2 == 0) begin
        if (roll < 50)      mode = ost_pkg::OP_ADD;
        else if (roll < 62) mode = ost_pkg::OP_CONTAINS;
        else if (roll < 72) mode = ost_pkg::OP_REMOVE;
        else if (roll < 95) mode = ost_pkg::OP_GET;
        else if (roll < 96) mode = ost_pkg::OP_CLEAR;
        else                mode = MODE_RSV5;
      end else begin
        if (roll < 20)      mode = ost_pkg::OP_ADD;
        else if (roll < 35) mode = ost_pkg::OP_CONTAINS;
        else if (roll < 65) mode = ost_pkg::OP_REMOVE;
        else if (roll < 93) mode = ost_pkg::OP_GET;
        else if (roll < 95) mode = ost_pkg::OP_CLEAR;
        else                mode = MODE_RSV5;
      end
      if (mode == MODE_RSV5) begin
        case ($urandom_range(0, 2))
          0:       mode = MODE_RSV5;
          1:       mode = MODE_RSV6;
          default: mode = MODE_RSV7;
        endcase
      end

      v = ($urandom_range(0, 99) < 80) ? pool[POOL_AW'($urandom_range(0, POOL_N - 1))]
                                        : $urandom;
      if (mode == ost_pkg::OP_GET && $urandom_range(0, 99) < 85)
        pos = ost_pkg::POS_W'($urandom_range(0, held_count));
      else
        pos = ost_pkg::POS_W'($urandom_range(0, 255));

      send_op(mode, v, pos, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    // Drain, then give a stray extra result time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * CAP + 8) @(posedge clk);

    $display("Covered %0d transactions (%0d scripted), %0d checked, %0d adds refused when full.",
             ops_sent, directed_sent, results_checked, refused_full);
    $display("Mix: add %0d contains %0d remove %0d get %0d clear %0d ignored %0d; %0d mismatches.",
             op_hits[ost_pkg::OP_ADD], op_hits[ost_pkg::OP_CONTAINS],
             op_hits[ost_pkg::OP_REMOVE], op_hits[ost_pkg::OP_GET],
             op_hits[ost_pkg::OP_CLEAR],
             op_hits[MODE_RSV5] + op_hits[MODE_RSV6] + op_hits[MODE_RSV7], mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ordered_set_table_top verification clean");
    end else begin
      $display("ordered_set_table_top verification failed");
    end
    $finish;
  end

endmodule
